@@ src/lec_pkg.sv @@
// ---------------------------------------------------------------------------
// Line ending converter package
// Shared constants, types and helpers for the CR-LF / LF converter.
// ---------------------------------------------------------------------------
`default_nettype none

package lec_pkg;

  // Width of the internal saturating counters.
  localparam int unsigned COUNT_WIDTH = 32;
  // Width of the reported count fields.
  localparam int unsigned OUT_COUNT_WIDTH = 32;
  // Most result beats one input byte can cause.
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned NUM_WIDTH = $clog2(MAX_RESULTS + 1);

  // Character codes.
  localparam logic [7:0] CH_CZ = 8'd26;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_DIRECTION   = 1'b0,
    REG_CTRLZ_CHECK = 1'b1
  } reg_idx_e;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [NUM_WIDTH-1:0]   num_t;

  // All result beats caused by one input byte.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;      // bytes in output order
    num_t                        num;        // number of beats, at least one
    logic                        bare;       // single end marker, no byte
    logic                        last;       // final beat closes the file
    count_t                      read_cnt;   // bytes read, this one included
    count_t                      line_cnt;   // line ends converted so far
  } burst_t;

  // Counter increment that holds at the all-ones value.
  function automatic count_t sat_inc(count_t v);
    count_t r;
    r = (v == '1) ? v : v + count_t'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/lec_if.sv @@
// ---------------------------------------------------------------------------
// Line ending converter stream interfaces
// Valid/ready channels for input bytes and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface lec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lec_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        end_of_run;
  logic [31:0] bytes_read;
  logic [31:0] bytes_written;
  logic [31:0] lines_done;

  modport source (output valid, output out_byte, output byte_valid, output end_of_run,
                  output bytes_read, output bytes_written, output lines_done,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input end_of_run,
                  input bytes_read, input bytes_written, input lines_done,
                  output ready);
endinterface

`default_nettype wire

@@ src/lec_step.sv @@
// ---------------------------------------------------------------------------
// Line ending converter step
// Holds the per-file state and turns one accepted byte into a result burst.
// ---------------------------------------------------------------------------
`default_nettype none

module lec_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic           in_last_i,
  input  wire logic           direction_i,
  input  wire logic           ctrlz_check_i,
  output logic                load_o,
  output lec_pkg::burst_t     burst_o
);

  logic            pend_valid_q, pend_valid_d;
  logic [7:0]      pend_byte_q, pend_byte_d;
  lec_pkg::count_t read_q, read_d;
  lec_pkg::count_t line_q, line_d;

  // Conversion of one byte: fills the burst slots in output order.
  always_comb begin
    lec_pkg::count_t rd_new;
    lec_pkg::count_t ln_new;
    lec_pkg::num_t   n;
    logic [lec_pkg::MAX_RESULTS-1:0][7:0] bytes;

    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    read_d       = read_q;
    line_d       = line_q;
    rd_new       = lec_pkg::sat_inc(read_q);
    ln_new       = line_q;
    n            = '0;
    bytes        = '0;

    if (accept_i) begin
      if (!direction_i) begin
        // CR-LF to LF: one byte is held back to pair a CR with its LF.
        if (!pend_valid_q) begin
          pend_byte_d  = in_byte_i;
          pend_valid_d = 1'b1;
        end else if (pend_byte_q == lec_pkg::CH_CR && in_byte_i == lec_pkg::CH_LF) begin
          ln_new       = lec_pkg::sat_inc(line_q);
          bytes[n]     = lec_pkg::CH_LF;
          n            = n + lec_pkg::num_t'(1);
          pend_valid_d = 1'b0;
        end else begin
          bytes[n]    = pend_byte_q;
          n           = n + lec_pkg::num_t'(1);
          pend_byte_d = in_byte_i;
        end
        // At end of file the held byte is flushed, unless it is a stripped control-Z.
        if (in_last_i && pend_valid_d &&
            !(ctrlz_check_i && pend_byte_d == lec_pkg::CH_CZ)) begin
          bytes[n] = pend_byte_d;
          n        = n + lec_pkg::num_t'(1);
        end
      end else begin
        // LF to CR-LF: every LF goes out as CR then LF.
        if (in_byte_i == lec_pkg::CH_LF) begin
          ln_new   = lec_pkg::sat_inc(line_q);
          bytes[n] = lec_pkg::CH_CR;
          n        = n + lec_pkg::num_t'(1);
          bytes[n] = lec_pkg::CH_LF;
          n        = n + lec_pkg::num_t'(1);
        end else begin
          bytes[n] = in_byte_i;
          n        = n + lec_pkg::num_t'(1);
        end
        // A DOS file must end in control-Z when checking is on.
        if (in_last_i && ctrlz_check_i && in_byte_i != lec_pkg::CH_CZ) begin
          bytes[n] = lec_pkg::CH_CZ;
          n        = n + lec_pkg::num_t'(1);
        end
      end

      read_d = rd_new;
      line_d = ln_new;

      // End of file returns every state entry to its start.
      if (in_last_i) begin
        pend_valid_d = 1'b0;
        pend_byte_d  = '0;
        read_d       = '0;
        line_d       = '0;
      end
    end

    load_o            = accept_i && (n != '0 || in_last_i);
    burst_o.bytes     = bytes;
    burst_o.bare      = (n == '0);
    burst_o.num       = (n == '0) ? lec_pkg::num_t'(1) : n;
    burst_o.last      = in_last_i;
    burst_o.read_cnt  = rd_new;
    burst_o.line_cnt  = ln_new;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_byte_q  <= '0;
      read_q       <= '0;
      line_q       <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_byte_q  <= pend_byte_d;
      read_q       <= read_d;
      line_q       <= line_d;
    end
  end

endmodule

`default_nettype wire

@@ src/lec_burst.sv @@
// ---------------------------------------------------------------------------
// Line ending converter result register
// Holds one result burst and gives out one beat per cycle while ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module lec_burst (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  lec_pkg::burst_t    burst_i,
  output logic               free_o,
  lec_out_if.source          out_o
);

  logic            busy_q;
  lec_pkg::num_t   idx_q;
  lec_pkg::burst_t burst_q;
  lec_pkg::count_t written_q;
  lec_pkg::count_t written_inc;
  logic            pop;
  logic            final_beat;
  logic            final_pop;

  assign pop         = busy_q && out_o.ready;
  assign final_beat  = (idx_q == lec_pkg::num_t'(burst_q.num - lec_pkg::num_t'(1)));
  assign final_pop   = pop && final_beat;
  assign free_o      = !busy_q || final_pop;
  assign written_inc = lec_pkg::sat_inc(written_q);

  // Beat fields.
  assign out_o.valid         = busy_q;
  assign out_o.out_byte      = burst_q.bare ? 8'd0 : burst_q.bytes[idx_q];
  assign out_o.byte_valid    = !burst_q.bare;
  assign out_o.end_of_run    = burst_q.last && final_beat;
  assign out_o.bytes_read    = lec_pkg::OUT_COUNT_WIDTH'(burst_q.read_cnt);
  assign out_o.bytes_written = lec_pkg::OUT_COUNT_WIDTH'(burst_q.bare ? written_q : written_inc);
  assign out_o.lines_done    = lec_pkg::OUT_COUNT_WIDTH'(burst_q.line_cnt);

  // Burst payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  // Beat sequencing and the written-byte counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      written_q <= '0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (final_pop) begin
        busy_q <= 1'b0;
      end else if (pop) begin
        idx_q <= idx_q + lec_pkg::num_t'(1);
      end

      if (pop) begin
        if (final_beat && burst_q.last) begin
          written_q <= '0;
        end else if (!burst_q.bare) begin
          written_q <= written_inc;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  // A new burst never overwrites beats still waiting.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("burst loaded while beats remain");

  // The beat index stays inside the burst.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < burst_q.num))
    else $error("beat index past burst length");

  // Closing a file clears the written count.
  a_eof_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && out_o.end_of_run) |=> (written_q == '0))
    else $error("written count not cleared at end of file");

  // A bare end marker is always a single closing beat.
  a_bare_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && burst_q.bare) |-> (burst_q.last && burst_q.num == lec_pkg::num_t'(1)))
    else $error("bare marker outside end of file");
`endif

endmodule

`default_nettype wire

@@ src/line_ending_converter_core.sv @@
// The first result beat of a byte is valid in the cycle after the byte is accepted.
// One result beat per cycle while the output is ready; a byte causing k beats (k up
// to 3) holds the input until its final beat leaves the single result register, so
// one byte per cycle at most. A byte that causes no beat is absorbed without stalling.
// Reset (rst_ni low, asynchronous): registers cleared to direction 0, no checking,
// nothing held and all counts zero; the block is ready once reset is released.
// ---------------------------------------------------------------------------
// Line ending converter core
// CR-LF / LF conversion with control-Z end-of-file rules and running counts.
// ---------------------------------------------------------------------------
`default_nettype none

module line_ending_converter_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_addr_i,
  input  wire logic [0:0] cfg_wdata_i,
  lec_in_if.sink          in_i,
  lec_out_if.source       out_o
);

  logic            direction_q;
  logic            ctrlz_check_q;
  logic            free;
  logic            accept;
  logic            load;
  lec_pkg::burst_t burst;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q   <= 1'b0;
      ctrlz_check_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lec_pkg::REG_DIRECTION:   direction_q   <= cfg_wdata_i[0];
        lec_pkg::REG_CTRLZ_CHECK: ctrlz_check_q <= cfg_wdata_i[0];
        default:                  ;
      endcase
    end
  end

  // Input handshake.
  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  lec_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_i.in_byte),
    .in_last_i     (in_i.in_last),
    .direction_i   (direction_q),
    .ctrlz_check_i (ctrlz_check_q),
    .load_o        (load),
    .burst_o       (burst)
  );

  lec_burst u_burst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .burst_i (burst),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_line_ending_converter_core.sv @@
// ---------------------------------------------------------------------------
// Line ending converter core testbench
// Sends files of bytes through the converter in both directions and with both
// control-Z rules, and checks every result beat against a cycle-free
// predictor of the conversion or, for typed table rows, the table's own beat.
// A short table of hand-picked bytes comes first, then random files of text-like
// content, under changing idle and stall patterns on the two streams.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_line_ending_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lec_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 500;
  localparam int LIMIT_CYCLES = 400000;

  // One result beat as seen on the output stream.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_run;
    logic [31:0] bytes_read;
    logic [31:0] bytes_written;
    logic [31:0] lines_done;
  } beat_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic       dir;
    logic       chk;
    logic [7:0] data;
    logic       last;
    logic       typed;
    beat_t      want;
  } row_t;

  localparam beat_t NO_BEAT = '0;

  localparam row_t DIRECTED [0:24] = '{
    // Single-byte files right after a file end: the results can be read off directly.
    '{1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0}},
    '{1'b0, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0}},
    '{1'b0, 1'b0, CH_CZ, 1'b1, 1'b1, '{CH_CZ, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0}},
    '{1'b0, 1'b1, CH_CZ, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 32'd1, 32'd0, 32'd0}},
    '{1'b0, 1'b1, 8'h55, 1'b1, 1'b1, '{8'h55, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0}},
    // CR-LF pair, then a held byte flushed by a CR on the last byte.
    '{1'b0, 1'b0, CH_CR, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, 1'b0, CH_LF, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, 1'b0, 8'h41, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, 1'b0, CH_CR, 1'b1, 1'b0, NO_BEAT},
    // Lone CR, CR-LF pair, then a trailing control-Z that is stripped.
    '{1'b0, 1'b1, CH_CR, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, 1'b1, CH_CR, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, 1'b1, CH_LF, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, 1'b1, CH_CZ, 1'b1, 1'b0, NO_BEAT},
    // Two bare LFs pass through unchanged.
    '{1'b0, 1'b1, CH_LF, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, 1'b1, CH_LF, 1'b1, 1'b0, NO_BEAT},
    // LF to CR-LF expansion, and the appended control-Z.
    '{1'b1, 1'b0, CH_LF, 1'b1, 1'b0, NO_BEAT},
    '{1'b1, 1'b0, 8'h80, 1'b1, 1'b1, '{8'h80, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0}},
    '{1'b1, 1'b1, CH_CZ, 1'b1, 1'b1, '{CH_CZ, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0}},
    '{1'b1, 1'b1, CH_LF, 1'b0, 1'b0, NO_BEAT},
    '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, NO_BEAT},
    '{1'b1, 1'b1, 8'h78, 1'b1, 1'b0, NO_BEAT},
    // Direction flipped inside a file: the held byte is never written.
    '{1'b0, 1'b0, 8'h51, 1'b0, 1'b0, NO_BEAT},
    '{1'b1, 1'b0, CH_LF, 1'b0, 1'b0, NO_BEAT},
    '{1'b1, 1'b0, 8'h7A, 1'b1, 1'b0, NO_BEAT},
    '{1'b1, 1'b0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0}}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  reg_idx_e  cfg_addr;
  logic      cfg_wdata;

  lec_in_if  in_ch ();
  lec_out_if out_ch ();

  line_ending_converter_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle and stall percentages of the current phase.
  int idle_pct   = 0;
  int stall_pct  = 0;
  int fail_count = 0;
  int sent       = 0;

  // Predictor state: configuration copy, held byte and running counts.
  logic       dir_q;
  logic       chk_q;
  logic       held_v;
  logic [7:0] held_b;
  logic [7:0] last_taken;
  count_t     n_read;
  count_t     n_written;
  count_t     n_lines;

  beat_t step_beats[$];
  beat_t due_beats[$];

  function automatic count_t bump(count_t v);
    bump = (&v) ? v : v + count_t'(1);
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    n_written = bump(n_written);
    step_beats.push_back('{out_byte: b, byte_valid: 1'b1, end_of_run: 1'b0,
                           bytes_read: n_read, bytes_written: n_written,
                           lines_done: n_lines});
  endtask

  // Works out the beats that one input byte causes and advances the state.
  task automatic convert_byte(input logic [7:0] c, input logic last);
    beat_t tail;
    step_beats.delete();
    n_read = bump(n_read);
    if (!dir_q) begin
      // CR-LF to LF: one byte is held back to pair a CR with the next LF.
      if (!held_v) begin
        held_b = c;
        held_v = 1'b1;
      end else if (held_b == CH_CR && c == CH_LF) begin
        n_lines = bump(n_lines);
        emit_byte(CH_LF);
        held_v = 1'b0;
      end else begin
        emit_byte(held_b);
        held_b = c;
      end
      if (last && held_v && !(chk_q && held_b == CH_CZ)) begin
        emit_byte(held_b);
      end
    end else begin
      // LF to CR-LF: every LF grows a CR in front of it.
      if (c == CH_LF) begin
        n_lines = bump(n_lines);
        emit_byte(CH_CR);
        emit_byte(CH_LF);
      end else begin
        emit_byte(c);
      end
      last_taken = c;
      if (last && chk_q && last_taken != CH_CZ) begin
        emit_byte(CH_CZ);
      end
    end
    // The last byte closes the file and returns everything to its start.
    if (last) begin
      if (step_beats.size() == 0) begin
        step_beats.push_back('{out_byte: 8'h00, byte_valid: 1'b0, end_of_run: 1'b1,
                               bytes_read: n_read, bytes_written: n_written,
                               lines_done: n_lines});
      end else begin
        tail = step_beats.pop_back();
        tail.end_of_run = 1'b1;
        step_beats.push_back(tail);
      end
      held_v     = 1'b0;
      held_b     = '0;
      last_taken = '0;
      n_read     = '0;
      n_written  = '0;
      n_lines    = '0;
    end
  endtask

  // Offers one byte after a random idle stretch and records what it owes.
  task automatic send_byte(input logic [7:0] c, input logic last, input logic typed,
                           input beat_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    convert_byte(c, last);
    if (typed) begin
      due_beats.push_back(want);
    end else begin
      foreach (step_beats[i]) due_beats.push_back(step_beats[i]);
    end
    sent++;
  endtask

  // Writes both registers once the converter has gone quiet.
  task automatic configure(input logic dir, input logic chk);
    in_ch.valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    // A byte that is only held leaves no beat behind, so give it time to settle.
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DIRECTION;
    cfg_wdata <= dir;
    @(posedge clk);
    cfg_addr  <= REG_CTRLZ_CHECK;
    cfg_wdata <= chk;
    @(posedge clk);
    cfg_we <= 1'b0;
    dir_q = dir;
    chk_q = chk;
  endtask

  // One random file: mostly text with line ends, some noise and control-Z.
  task automatic random_file();
    logic [7:0] text[$];
    int         len;
    int         pick;
    int         split;
    if ($urandom_range(99) < 30) begin
      configure(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(11, 1);
    while (text.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        text.push_back(8'($urandom_range(126, 32)));
      end else if (pick < 55) begin
        text.push_back(CH_CR);
        text.push_back(CH_LF);
      end else if (pick < 65) begin
        text.push_back(CH_LF);
      end else if (pick < 73) begin
        text.push_back(CH_CR);
      end else if (pick < 81) begin
        text.push_back(CH_CZ);
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(99) < 30) begin
      text[text.size() - 1] = CH_CZ;
    end
    // Now and then the direction flips partway through the file.
    split = -1;
    if (text.size() > 1 && $urandom_range(99) < 6) begin
      split = $urandom_range(text.size() - 1, 1);
    end
    for (int i = 0; i < text.size(); i++) begin
      if (i == split) begin
        configure(~dir_q, chk_q);
      end
      send_byte(text[i], i == text.size() - 1, 1'b0, NO_BEAT);
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
    fail_count++;
  endtask

  // Compares one accepted beat with the oldest one still owed.
  task automatic check_beat(input beat_t got);
    beat_t want;
    if (due_beats.size() == 0) begin
      $display("%0t: beat with none expected, expected none, got byte 'h%0h end %0b",
               $time, got.out_byte, got.end_of_run);
      fail_count++;
    end else begin
      want = due_beats.pop_front();
      if (got.out_byte !== want.out_byte) begin
        report_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      end
      if (got.byte_valid !== want.byte_valid) begin
        report_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
      end
      if (got.end_of_run !== want.end_of_run) begin
        report_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
      end
      if (got.bytes_read !== want.bytes_read) begin
        report_field("bytes_read", want.bytes_read, got.bytes_read);
      end
      if (got.bytes_written !== want.bytes_written) begin
        report_field("bytes_written", want.bytes_written, got.bytes_written);
      end
      if (got.lines_done !== want.lines_done) begin
        report_field("lines_done", want.lines_done, got.lines_done);
      end
    end
  endtask

  // Output side: take beats under random stall and check each one.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_beat('{out_byte: out_ch.out_byte, byte_valid: out_ch.byte_valid,
                     end_of_run: out_ch.end_of_run, bytes_read: out_ch.bytes_read,
                     bytes_written: out_ch.bytes_written,
                     lines_done: out_ch.lines_done});
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on the whole run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles <= LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus: reset, the directed table, then random files in four phases.
  initial begin
    int idle_plan [0:3];
    int stall_plan[0:3];
    int target;
    idle_plan  = '{0, 87, 0, 28};
    stall_plan = '{0, 0, 87, 28};
    dir_q      = 1'b0;
    chk_q      = 1'b0;
    held_v     = 1'b0;
    held_b     = '0;
    last_taken = '0;
    n_read     = '0;
    n_written  = '0;
    n_lines    = '0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= REG_DIRECTION;
    cfg_wdata     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (i == 0 || DIRECTED[i].dir != dir_q || DIRECTED[i].chk != chk_q) begin
        configure(DIRECTED[i].dir, DIRECTED[i].chk);
      end
      send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      target    = sent + RANDOM_ITEMS / 4;
      while (sent < target) random_file();
    end
    in_ch.valid <= 1'b0;

    // Drain: every owed beat must arrive, then no stray beat may follow.
    while (due_beats.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
